@@ design/fmr_pkg.sv @@
// Shared types and codes for the framed message receiver.
package fmr_pkg;

   // Receive phase of the deframer.
   typedef enum logic [2:0] {
      PH_HUNT_HEAD = 3'd0,
      PH_HUNT_TYPE = 3'd1,
      PH_LEN_HI    = 3'd2,
      PH_LEN_LO    = 3'd3,
      PH_PAYLOAD   = 3'd4,
      PH_TRAILER   = 3'd5,
      PH_END       = 3'd6
   } phase_type;

   // Result kinds carried on rsp_tuser.
   localparam logic [1:0] KIND_PAYLOAD     = 2'd0;
   localparam logic [1:0] KIND_COMPLETE    = 2'd1;
   localparam logic [1:0] KIND_TRAILER_ERR = 2'd2;
   localparam logic [1:0] KIND_END_ERR     = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_EXPECTED_TYPE = 2'd0;
   localparam logic [1:0] REG_HEAD_BYTE     = 2'd1;
   localparam logic [1:0] REG_TRAILER_BYTE  = 2'd2;
   localparam logic [1:0] REG_END_BYTE      = 2'd3;

   // Configuration reset values.
   localparam logic [7:0] RST_EXPECTED_TYPE = 8'h00;
   localparam logic [7:0] RST_HEAD_BYTE     = 8'hFF;
   localparam logic [7:0] RST_TRAILER_BYTE  = 8'hFD;
   localparam logic [7:0] RST_END_BYTE      = 8'hFC;

endpackage

@@ design/framed_message_receiver_top.sv @@
// Framed message receiver: a length-prefixed byte stream deframer.
//
// Bytes enter on the req_ stream, one per transfer. The block hunts for the
// head byte followed by the expected type byte, reads a big-endian length,
// then passes each payload byte out on the rsp_ stream with its index.
// After the payload it checks the trailer and end bytes and sends one
// transfer: frame complete with the length, or a trailer or end mismatch
// with the offending byte. Header bytes produce no output transfer.
// An accepted byte passes through the input register and then the result
// register before its result appears on rsp_. Throughput is one byte per
// cycle while rsp_tready does not stall the result register.
// When rsp_tready is low, a pending result holds and the input register
// fills, after which req_tready drops until the result is taken.
// Reset is synchronous and clears both stages, returns the block to hunting
// for the head byte and loads the default framing bytes. Users must write the
// csr_ port only while no frame bytes are in flight; nothing enforces it.
module framed_message_receiver_top
   import fmr_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                    // [39:24] frame_length
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] expected_type_ff;
   logic [7:0] head_byte_ff;
   logic [7:0] trailer_byte_ff;
   logic [7:0] end_byte_ff;

   // Input register stage.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Frame state.
   phase_type              phase_ff, phase_in;
   logic [7:0]             length_high_ff, length_high_in;
   logic [LENGTH_BITS-1:0] declared_length_ff, declared_length_in;
   logic [LENGTH_BITS-1:0] payload_count_ff, payload_count_in;
   logic [LENGTH_BITS-1:0] count_plus_one;
   logic [LENGTH_BITS-1:0] assembled_length;

   // Result register stage.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_length_ff, rsp_length_in;
   logic        has_result;

   logic advance;
   logic step;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign count_plus_one   = payload_count_ff + LENGTH_BITS'(1);
   assign assembled_length = LENGTH_BITS'({length_high_ff, in_byte_ff});

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= RST_EXPECTED_TYPE;
         head_byte_ff     <= RST_HEAD_BYTE;
         trailer_byte_ff  <= RST_TRAILER_BYTE;
         end_byte_ff      <= RST_END_BYTE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_EXPECTED_TYPE: expected_type_ff <= csr_wdata;
            REG_HEAD_BYTE:     head_byte_ff     <= csr_wdata;
            REG_TRAILER_BYTE:  trailer_byte_ff  <= csr_wdata;
            REG_END_BYTE:      end_byte_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT_TYPE:
               phase_in = (in_byte_ff == expected_type_ff) ? PH_LEN_HI : PH_HUNT_HEAD;
            PH_LEN_HI:
               phase_in = PH_LEN_LO;
            PH_LEN_LO:
               phase_in = (assembled_length == '0) ? PH_TRAILER : PH_PAYLOAD;
            PH_PAYLOAD:
               phase_in = (count_plus_one >= declared_length_ff) ? PH_TRAILER : PH_PAYLOAD;
            PH_TRAILER:
               phase_in = (in_byte_ff == trailer_byte_ff) ? PH_END : PH_HUNT_HEAD;
            PH_END:
               phase_in = PH_HUNT_HEAD;
            default:
               phase_in = (in_byte_ff == head_byte_ff) ? PH_HUNT_TYPE : PH_HUNT_HEAD;
         endcase
      end
   end

   // Datapath and result outputs for the current phase.
   always_comb begin
      length_high_in     = length_high_ff;
      declared_length_in = declared_length_ff;
      payload_count_in   = payload_count_ff;
      has_result         = 1'b0;
      rsp_kind_in        = KIND_PAYLOAD;
      rsp_data_in        = in_byte_ff;
      rsp_index_in       = '0;
      rsp_length_in      = 16'(declared_length_ff);
      unique case (phase_ff)
         PH_LEN_HI: begin
            length_high_in = in_byte_ff;
         end
         PH_LEN_LO: begin
            declared_length_in = assembled_length;
            payload_count_in   = '0;
         end
         PH_PAYLOAD: begin
            has_result       = 1'b1;
            rsp_kind_in      = KIND_PAYLOAD;
            rsp_index_in     = 16'(payload_count_ff);
            payload_count_in = count_plus_one;
         end
         PH_TRAILER: begin
            has_result  = (in_byte_ff != trailer_byte_ff);
            rsp_kind_in = KIND_TRAILER_ERR;
         end
         PH_END: begin
            has_result = 1'b1;
            if (in_byte_ff == end_byte_ff) begin
               rsp_kind_in = KIND_COMPLETE;
               rsp_data_in = '0;
            end else begin
               rsp_kind_in = KIND_END_ERR;
            end
         end
         default: ;
      endcase
      rsp_valid_in = advance ? (in_valid_ff && has_result) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         phase_ff           <= PH_HUNT_HEAD;
         length_high_ff     <= '0;
         declared_length_ff <= '0;
         payload_count_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            length_high_ff     <= length_high_in;
            declared_length_ff <= declared_length_in;
            payload_count_ff   <= payload_count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (step && has_result) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_index_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

@@ sim/framed_message_receiver_checker.sv @@
`timescale 1ns / 100ps
// Checker for the deframer: mirrors the receive phases, predicts results, compares transfers.
module framed_message_receiver_checker
   import fmr_pkg::*;
#(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          outstanding,
   output int          results_checked,
   output int          frames_closed,
   output int          framing_errors
);

   localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 1);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
   } frame_event_type;

   frame_event_type frame_events_due[$];
   frame_event_type oldest;

   phase_type   phase;
   logic [7:0]  len_hi_byte;
   logic [15:0] frame_len;
   logic [15:0] payload_seen;
   logic [7:0]  type_reg, head_reg, trailer_reg, end_reg;

   // Advances the mirrored receive phase by one byte and queues the result it causes.
   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] assembled;
      case (phase)
         PH_HUNT_TYPE: phase = (b == type_reg) ? PH_LEN_HI : PH_HUNT_HEAD;
         PH_LEN_HI: begin
            len_hi_byte = b;
            phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            assembled = {len_hi_byte, b} & LEN_MASK;
            frame_len = assembled;
            payload_seen = '0;
            phase = (assembled == '0) ? PH_TRAILER : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            frame_events_due.push_back({KIND_PAYLOAD, b, payload_seen, frame_len});
            payload_seen = payload_seen + 16'd1;
            if (payload_seen >= frame_len) phase = PH_TRAILER;
         end
         PH_TRAILER: begin
            if (b == trailer_reg) begin
               phase = PH_END;
            end else begin
               frame_events_due.push_back({KIND_TRAILER_ERR, b, 16'd0, frame_len});
               phase = PH_HUNT_HEAD;
            end
         end
         PH_END: begin
            if (b == end_reg) begin
               frame_events_due.push_back({KIND_COMPLETE, 8'd0, 16'd0, frame_len});
            end else begin
               frame_events_due.push_back({KIND_END_ERR, b, 16'd0, frame_len});
            end
            phase = PH_HUNT_HEAD;
         end
         // A byte that failed as type, trailer or end lands here only on the next transfer,
         // so it is never tested as a head byte itself.
         default: phase = (b == head_reg) ? PH_HUNT_TYPE : PH_HUNT_HEAD;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_events_due.delete();
         phase = PH_HUNT_HEAD;
         len_hi_byte = '0;
         frame_len = '0;
         payload_seen = '0;
         type_reg = RST_EXPECTED_TYPE;
         head_reg = RST_HEAD_BYTE;
         trailer_reg = RST_TRAILER_BYTE;
         end_reg = RST_END_BYTE;
         fail_count = 0;
         results_checked = 0;
         frames_closed = 0;
         framing_errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_EXPECTED_TYPE: type_reg = csr_wdata;
               REG_HEAD_BYTE:     head_reg = csr_wdata;
               REG_TRAILER_BYTE:  trailer_reg = csr_wdata;
               REG_END_BYTE:      end_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (frame_events_due.size() == 0) begin
               $error("unexpected result transfer: kind %0d, tdata %h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               oldest = frame_events_due.pop_front();
               if (rsp_tuser !== oldest.kind) begin
                  $error("kind mismatch: expected %0d, got %0d", oldest.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[7:0] !== oldest.data_byte) begin
                  $error("data_byte mismatch: expected %h, got %h",
                         oldest.data_byte, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[23:8] !== oldest.byte_index) begin
                  $error("byte_index mismatch: expected %0d, got %0d",
                         oldest.byte_index, rsp_tdata[23:8]);
                  fail_count++;
               end
               if (rsp_tdata[39:24] !== oldest.frame_length) begin
                  $error("frame_length mismatch: expected %0d, got %0d",
                         oldest.frame_length, rsp_tdata[39:24]);
                  fail_count++;
               end
               results_checked++;
               if (oldest.kind == KIND_COMPLETE) frames_closed++;
               else if (oldest.kind != KIND_PAYLOAD) framing_errors++;
            end
         end
      end
      outstanding <= frame_events_due.size();
   end

endmodule

@@ sim/framed_message_receiver_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives framed byte streams and framing settings into the deframer and reports.
module framed_message_receiver_top_tb;
   import fmr_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int FRAMED_BYTE_TARGET = 750;
   localparam int SETTING_ROUNDS = 6;

   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_TYPE,
      SHAPE_BAD_TRAILER,
      SHAPE_BAD_END,
      SHAPE_NOISE
   } frame_shape_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] data_byte, [23:8] byte_index, [39:24] frame_length
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = REG_EXPECTED_TYPE;
   logic [7:0]  csr_wdata = 8'd0;

   int fail_count, outstanding, results_checked, frames_closed, framing_errors;

   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   int          framed_bytes = 0;
   logic [7:0]  cfg_type = RST_EXPECTED_TYPE;
   logic [7:0]  cfg_head = RST_HEAD_BYTE;
   logic [7:0]  cfg_trailer = RST_TRAILER_BYTE;
   logic [7:0]  cfg_end = RST_END_BYTE;

   // Opening sequence under the reset framing bytes: noise, an empty frame, a head byte
   // whose type slot holds another head byte, a trailer error on a head-valued byte, then
   // a frame whose end byte is wrong.
   logic [7:0] opening_bytes [25] = '{
      8'h00, 8'hFE,
      8'hFF, 8'h00, 8'h00, 8'h00, 8'hFD, 8'hFC,
      8'hFF, 8'hFF, 8'h00,
      8'hFF, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF,
      8'hFF, 8'h00, 8'h00, 8'h01, 8'hA5, 8'hFD, 8'h00
   };

   framed_message_receiver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   framed_message_receiver_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .frames_closed   (frames_closed),
      .framing_errors  (framing_errors)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver back-pressure comes in random bursts while idle_on is set.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Holds the sender off until every predicted result has been taken, then lets the
   // pipeline drain bytes that produce no result.
   task automatic settle(input int tail_cycles);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (tail_cycles) @(posedge clock);
   endtask

   task automatic load_framing(input logic [7:0] t, input logic [7:0] h,
                               input logic [7:0] tr, input logic [7:0] e);
      csr_wr_en <= 1'b1;
      csr_index <= REG_EXPECTED_TYPE;
      csr_wdata <= t;
      @(posedge clock);
      csr_index <= REG_HEAD_BYTE;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= REG_TRAILER_BYTE;
      csr_wdata <= tr;
      @(posedge clock);
      csr_index <= REG_END_BYTE;
      csr_wdata <= e;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_type = t;
      cfg_head = h;
      cfg_trailer = tr;
      cfg_end = e;
   endtask

   task automatic send_frame(input frame_shape_type shape, input logic [15:0] len);
      int n;
      if (shape == SHAPE_NOISE) begin
         // Noise never carries the head byte, so the deframer keeps hunting.
         n = $urandom_range(1, 5);
         repeat (n) push_byte(cfg_head + 8'($urandom_range(1, 255)));
         return;
      end
      push_byte(cfg_head);
      if (shape == SHAPE_BAD_TYPE) begin
         push_byte(cfg_type + 8'($urandom_range(1, 255)));
         framed_bytes += 2;
         return;
      end
      push_byte(cfg_type);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      for (int i = 0; i < len; i++) push_byte(8'($urandom));
      if (shape == SHAPE_BAD_TRAILER) begin
         push_byte(cfg_trailer + 8'($urandom_range(1, 255)));
         framed_bytes += 5 + len;
         return;
      end
      push_byte(cfg_trailer);
      push_byte((shape == SHAPE_BAD_END) ? cfg_end + 8'($urandom_range(1, 255)) : cfg_end);
      framed_bytes += 6 + len;
   endtask

   initial begin
      int pick;
      logic [15:0] len;
      frame_shape_type shape;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) push_byte(opening_bytes[i]);

      // One long frame whose length has a zero low byte and a nonzero high byte.
      settle(4);
      load_framing(8'hFF, 8'h00, 8'h00, 8'hFF);
      send_frame(SHAPE_GOOD, 16'h0100);
      framed_bytes = 0;

      for (int round = 0; round < SETTING_ROUNDS; round++) begin
         settle(4);
         case (round)
            1: load_framing(8'h00, 8'h00, 8'h00, 8'h00);
            2: load_framing(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            SETTING_ROUNDS - 1: begin
               idle_on = 1'b0;
               load_framing(RST_EXPECTED_TYPE, RST_HEAD_BYTE, RST_TRAILER_BYTE, RST_END_BYTE);
            end
            default: load_framing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         while (framed_bytes < (round + 1) * FRAMED_BYTE_TARGET / SETTING_ROUNDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) shape = SHAPE_GOOD;
            else if (pick < 70) shape = SHAPE_BAD_TYPE;
            else if (pick < 79) shape = SHAPE_BAD_TRAILER;
            else if (pick < 88) shape = SHAPE_BAD_END;
            else shape = SHAPE_NOISE;
            case ($urandom_range(0, 9))
               0:       len = 16'($urandom_range(41, 700));
               1, 2, 3: len = 16'($urandom_range(7, 40));
               default: len = 16'($urandom_range(0, 6));
            endcase
            send_frame(shape, len);
         end
      end

      settle(8);
      $display("Sent %0d bytes across several framing settings, with one long frame.",
               bytes_sent);
      $display("Checked %0d results: %0d frames closed, %0d framing errors.",
               results_checked, frames_closed, framing_errors);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
